// ===== rtl/core/lzss_flag_byte_decompressor_macros.svh =====
// Assertion macros used by the decompressor control module.
`ifndef LZSS_FLAG_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZSS_FLAG_BYTE_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
`define LZSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LZSS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LZSS_ASSERT(label, prop, msg)
`define LZSS_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/core/lzss_fbd_pkg.sv =====
// Shared types and constants of the flag-byte decompressor.
package lzss_fbd_pkg;

    localparam int WINDOW_BYTES_DEF = 16384;
    localparam int PC_W             = 24;
    localparam int DIST_W           = 14;
    localparam int LEN_W            = 7;
    localparam int MAX_COPY         = 64;
    localparam int FLAG_BITS        = 8;
    localparam int UNIT_MAX         = 4;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIAS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 2'd2;

    localparam logic [2:0]      UNIT_RESET  = 3'd1;
    localparam logic [1:0]      BIAS_RESET  = 2'd2;
    localparam logic [PC_W-1:0] LIMIT_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       complete;
    } emit_t;

endpackage

// ===== rtl/core/lzss_fbd_window.sv =====
// History window memory with write-to-read forwarding.
module lzss_fbd_window #(
    parameter int WINDOW_BYTES = lzss_fbd_pkg::WINDOW_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [$clog2(WINDOW_BYTES)-1:0] waddr,
    input  logic [7:0]                      wdata,
    input  logic [$clog2(WINDOW_BYTES)-1:0] raddr,
    output logic [7:0]                      rdata
);
    logic [7:0] mem [WINDOW_BYTES];
    logic [7:0] q_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg        <= mem[raddr];
        fwd_data_reg <= wdata;
    end

    // A read of the entry being written in the same cycle returns the new byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ===== rtl/core/lzss_fbd_outreg.sv =====
// Output register that holds one result item until it is taken.
module lzss_fbd_outreg (
    input  logic                clk,
    input  logic                rst_n,
    input  lzss_fbd_pkg::emit_t push,
    input  logic                out_stall,
    output logic                out_space,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                last_of_run,
    output logic                output_complete
);
    import lzss_fbd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       complete_reg;

    assign out_space = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            byte_reg     <= push.data;
            last_reg     <= push.last;
            complete_reg <= push.complete;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign last_of_run     = last_reg;
    assign output_complete = complete_reg;

endmodule

// ===== rtl/core/lzss_fbd_ctrl.sv =====
// Token parser, match copy sequencer and configuration registers.
`include "lzss_flag_byte_decompressor_macros.svh"
module lzss_fbd_ctrl #(
    parameter int WINDOW_BYTES = lzss_fbd_pkg::WINDOW_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lzss_fbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lzss_fbd_pkg::PC_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic                                 stream_start,
    input  logic                                 out_space,
    output lzss_fbd_pkg::emit_t                  emit,
    output logic                                 mem_we,
    output logic [$clog2(WINDOW_BYTES)-1:0]      mem_waddr,
    output logic [7:0]                           mem_wdata,
    output logic [$clog2(WINDOW_BYTES)-1:0]      mem_raddr,
    input  logic [7:0]                           mem_rdata
);
    import lzss_fbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int CW = ((DIST_W > AW) ? DIST_W : AW) + 1;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_COPY   = 2'd2;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        bits_reg, bits_next;
    logic [3:0]        pos_reg, pos_next;
    logic [2:0]        lit_reg, lit_next;
    logic [7:0]        off_low_reg, off_low_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [2:0]        unit_reg;
    logic [1:0]        bias_reg;
    logic [PC_W-1:0]   limit_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DIST_W-1:0] dmod_reg, dmod_next;
    logic [AW-1:0]     rptr_reg, rptr_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;

    logic              accept;
    logic              halted;
    logic [2:0]        u_eff;
    logic [15:0]       word;
    logic [DIST_W-1:0] dist_calc;
    logic [4:0]        len_sum;
    logic [LEN_W-1:0]  len_prod;
    logic [LEN_W-1:0]  len_cap;
    logic [PC_W-1:0]   pc_plus;
    logic              src_ok;
    logic [7:0]        copy_byte;
    logic [CW-1:0]     dmod_ext;
    logic [CW-1:0]     wptr_ext;
    logic [CW-1:0]     win_ext;
    logic              sel_req;
    logic [3:0]        sel_pos;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(WINDOW_BYTES - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    assign u_eff     = (unit_reg == 3'd0) ? 3'd1 :
                       (unit_reg > 3'(UNIT_MAX)) ? 3'(UNIT_MAX) : unit_reg;
    assign word      = {data_byte, off_low_reg};
    assign dist_calc = DIST_W'(word[15:4]) * DIST_W'(u_eff);
    assign len_sum   = 5'(word[3:0]) + 5'(bias_reg);
    assign len_prod  = LEN_W'(len_sum) * LEN_W'(u_eff);
    assign len_cap   = (len_prod > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY) : len_prod;
    assign pc_plus   = pc_reg + 1'b1;
    assign halted    = pc_reg >= limit_reg;
    assign src_ok    = (dist_reg != '0) && (PC_W'(dist_reg) <= pc_reg);
    assign copy_byte = src_ok ? mem_rdata : 8'd0;
    assign dmod_ext  = CW'(dmod_reg);
    assign wptr_ext  = CW'(wptr_reg);
    assign win_ext   = CW'(WINDOW_BYTES);

    assign in_stall  = !((state_reg == ST_ACCEPT) && out_space);
    assign accept    = in_valid && !in_stall;

    assign mem_waddr = wptr_reg;
    assign mem_raddr = rptr_next;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bits_next    = bits_reg;
        pos_next     = pos_reg;
        lit_next     = lit_reg;
        off_low_next = off_low_reg;
        pc_next      = pc_reg;
        wptr_next    = wptr_reg;
        dist_next    = dist_reg;
        dmod_next    = dmod_reg;
        rptr_next    = rptr_reg;
        cnt_next     = cnt_reg;
        sel_req      = 1'b0;
        sel_pos      = pos_reg;
        emit         = '0;
        mem_we       = 1'b0;
        mem_wdata    = data_byte;

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    if (stream_start)
                    begin
                        pc_next   = '0;
                        wptr_next = '0;
                        bits_next = data_byte;
                        sel_req   = 1'b1;
                        sel_pos   = 4'd0;
                    end
                    else if (!halted)
                    begin
                        unique case (phase_reg)
                            PH_FLAG:
                            begin
                                bits_next = data_byte;
                                sel_req   = 1'b1;
                                sel_pos   = 4'd0;
                            end
                            PH_LIT:
                            begin
                                emit.valid    = 1'b1;
                                emit.data     = data_byte;
                                emit.last     = 1'b1;
                                emit.complete = (pc_plus == limit_reg);
                                mem_we        = 1'b1;
                                pc_next       = pc_plus;
                                wptr_next     = wrap_inc(wptr_reg);
                                lit_next      = (lit_reg == 3'd0) ? 3'd0 : lit_reg - 1'b1;
                                if (lit_reg <= 3'd1)
                                begin
                                    sel_req = 1'b1;
                                    sel_pos = pos_reg + 1'b1;
                                end
                            end
                            PH_LOW:
                            begin
                                off_low_next = data_byte;
                                phase_next   = PH_HIGH;
                            end
                            PH_HIGH:
                            begin
                                dist_next = dist_calc;
                                dmod_next = dist_calc;
                                cnt_next  = len_cap;
                                if (len_cap == '0)
                                begin
                                    sel_req = 1'b1;
                                    sel_pos = pos_reg + 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_SETUP;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_SETUP:
            begin
                // Bring the distance below the window size, then place the read pointer.
                if (dmod_ext >= win_ext)
                begin
                    dmod_next = DIST_W'(dmod_ext - win_ext);
                end
                else
                begin
                    rptr_next  = (wptr_ext >= dmod_ext) ? AW'(wptr_ext - dmod_ext)
                                                        : AW'(wptr_ext + win_ext - dmod_ext);
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (out_space)
                begin
                    emit.valid    = 1'b1;
                    emit.data     = copy_byte;
                    emit.last     = (cnt_reg == LEN_W'(1)) || (pc_plus == limit_reg);
                    emit.complete = (pc_plus == limit_reg);
                    mem_we        = 1'b1;
                    mem_wdata     = copy_byte;
                    pc_next       = pc_plus;
                    wptr_next     = wrap_inc(wptr_reg);
                    rptr_next     = wrap_inc(rptr_reg);
                    cnt_next      = cnt_reg - 1'b1;
                    if (emit.last)
                    begin
                        sel_req    = 1'b1;
                        sel_pos    = pos_reg + 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase

        if (sel_req)
        begin
            if (sel_pos >= 4'(FLAG_BITS))
            begin
                phase_next = PH_FLAG;
                pos_next   = 4'(FLAG_BITS);
            end
            else if (bits_next[sel_pos[2:0]])
            begin
                phase_next = PH_LIT;
                lit_next   = u_eff;
                pos_next   = sel_pos;
            end
            else
            begin
                phase_next = PH_LOW;
                pos_next   = sel_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCEPT;
            phase_reg   <= PH_FLAG;
            bits_reg    <= '0;
            pos_reg     <= 4'(FLAG_BITS);
            lit_reg     <= '0;
            off_low_reg <= '0;
            pc_reg      <= '0;
            wptr_reg    <= '0;
            unit_reg    <= UNIT_RESET;
            bias_reg    <= BIAS_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bits_reg    <= bits_next;
            pos_reg     <= pos_next;
            lit_reg     <= lit_next;
            off_low_reg <= off_low_next;
            pc_reg      <= pc_next;
            wptr_reg    <= wptr_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_UNIT_BYTES:   unit_reg  <= cfg_data[2:0];
                    CFG_LENGTH_BIAS:  bias_reg  <= cfg_data[1:0];
                    CFG_OUTPUT_LIMIT: limit_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        dmod_reg <= dmod_next;
        rptr_reg <= rptr_next;
        cnt_reg  <= cnt_next;
    end

    `LZSS_ASSERT(a_emit_space, emit.valid |-> out_space, "Item emitted without output space")
    `LZSS_NEVER(a_busy_stall, (state_reg != ST_ACCEPT) && !in_stall, "Input open while busy")
    `LZSS_ASSERT(a_copy_cnt, (state_reg == ST_COPY) |-> (cnt_reg != '0), "Copy with no bytes left")
    `LZSS_ASSERT(a_copy_done, (state_reg == ST_COPY) && emit.valid && emit.last |=> (state_reg == ST_ACCEPT), "Copy did not end after its last item")

endmodule

// ===== rtl/core/lzss_flag_byte_decompressor.sv =====
// Top level of the flag-byte LZSS decompressor.
// A literal result appears in the cycle after its byte is taken.
// A match high byte starts a distance setup, then up to 64 bytes are copied, one per cycle
// while the output has space, paced by the single read port of the history window memory.
// Reset clears the parser state and loads the configuration defaults; the window
// contents stay undefined and need no clearing pass.
module lzss_flag_byte_decompressor #(
    parameter int WINDOW_BYTES = lzss_fbd_pkg::WINDOW_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lzss_fbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzss_fbd_pkg::PC_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                stream_start,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,
    output logic                                last_of_run,
    output logic                                output_complete
);
    import lzss_fbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    emit_t         emit;
    logic          out_space;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    lzss_fbd_ctrl #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .stream_start(stream_start),
        .out_space   (out_space),
        .emit        (emit),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    lzss_fbd_window #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_window (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    lzss_fbd_outreg u_outreg (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (emit),
        .out_stall      (out_stall),
        .out_space      (out_space),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .output_complete(output_complete)
    );

endmodule

// ===== tb/lzss_fbd_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the decompressed byte stream and compares it with the block's results.
module lzss_fbd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [lzss_fbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lzss_fbd_pkg::PC_W-1:0]      cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               stream_start,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [7:0]                         out_byte,
    input  logic                               last_of_run,
    input  logic                               output_complete,
    output int                                 awaiting,
    output int                                 mismatches
);
    import lzss_fbd_pkg::*;

    localparam int WIN = WINDOW_BYTES_DEF;

    typedef enum logic [1:0] {AWAIT_FLAG, IN_LITERAL, AWAIT_LOW, AWAIT_HIGH} parse_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       done;
    } out_item_t;

    out_item_t       pending_bytes [$];
    logic [7:0]      window [WIN];
    logic [2:0]      unit_reg;
    logic [1:0]      bias_reg;
    logic [PC_W-1:0] limit_reg;
    parse_t          phase;
    logic [7:0]      flags;
    logic [7:0]      low_byte;
    int unsigned     flag_pos;
    int unsigned     lit_left;
    int unsigned     produced;
    int              errs;

    function automatic int unsigned unit_eff();
        if (unit_reg == 3'd0)
            return 1;
        if (unit_reg > 3'(UNIT_MAX))
            return UNIT_MAX;
        return 32'(unit_reg);
    endfunction

    task automatic pick_token();
        if (flag_pos >= FLAG_BITS)
        begin
            phase = AWAIT_FLAG;
            flag_pos = FLAG_BITS;
        end
        else if (flags[flag_pos])
        begin
            phase = IN_LITERAL;
            lit_left = unit_eff();
        end
        else
        begin
            phase = AWAIT_LOW;
        end
    endtask

    task automatic put_byte(input logic [7:0] value);
        out_item_t item;
        window[produced % WIN] = value;
        produced++;
        item.value = value;
        item.last = 1'b0;
        item.done = (produced == 32'(limit_reg));
        pending_bytes = {pending_bytes, item};
    endtask

    task automatic decode_item(input logic [7:0] value, input logic restart);
        int unsigned before_size;
        int unsigned match_dist;
        int unsigned len;
        int unsigned i;
        logic [15:0] word;
        logic [7:0]  copied;
        before_size = pending_bytes.size();
        if (restart)
        begin
            produced = 0;
            flags = value;
            flag_pos = 0;
            pick_token();
        end
        else if (produced < 32'(limit_reg))
        begin
            case (phase)
                AWAIT_FLAG:
                begin
                    flags = value;
                    flag_pos = 0;
                    pick_token();
                end
                IN_LITERAL:
                begin
                    put_byte(value);
                    if (lit_left > 0)
                        lit_left--;
                    if (lit_left == 0)
                    begin
                        flag_pos++;
                        pick_token();
                    end
                end
                AWAIT_LOW:
                begin
                    low_byte = value;
                    phase = AWAIT_HIGH;
                end
                default:
                begin
                    word = {value, low_byte};
                    match_dist = 32'(word[15:4]) * unit_eff();
                    len = (32'(word[3:0]) + 32'(bias_reg)) * unit_eff();
                    if (len > MAX_COPY)
                        len = MAX_COPY;
                    for (i = 0; i < len && produced < 32'(limit_reg); i++)
                    begin
                        copied = 8'h00;
                        if (match_dist != 0 && match_dist <= produced)
                            copied = window[(produced - match_dist) % WIN];
                        put_byte(copied);
                    end
                    flag_pos++;
                    pick_token();
                end
            endcase
        end
        if (pending_bytes.size() > before_size)
        begin
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        logic      bad;
        if (!rst_n)
        begin
            pending_bytes.delete();
            unit_reg = UNIT_RESET;
            bias_reg = BIAS_RESET;
            limit_reg = LIMIT_RESET;
            phase = AWAIT_FLAG;
            flags = 8'h00;
            low_byte = 8'h00;
            flag_pos = FLAG_BITS;
            lit_left = 0;
            produced = 0;
            errs = 0;
            awaiting <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_UNIT_BYTES:   unit_reg = cfg_data[2:0];
                    CFG_LENGTH_BIAS:  bias_reg = cfg_data[1:0];
                    CFG_OUTPUT_LIMIT: limit_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                decode_item(data_byte, stream_start);
            if (out_valid && !out_stall)
            begin
                if (pending_bytes.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result out_byte %02h last_of_run %0b %s %0b",
                             $time, out_byte, last_of_run, "output_complete",
                             output_complete);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    bad = 1'b0;
                    if (out_byte !== want.value)
                    begin
                        bad = 1'b1;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.value, out_byte);
                    end
                    if (last_of_run !== want.last)
                    begin
                        bad = 1'b1;
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last, last_of_run);
                    end
                    if (output_complete !== want.done)
                    begin
                        bad = 1'b1;
                        $display("%0t: output_complete expected %0b actual %0b",
                                 $time, want.done, output_complete);
                    end
                    if (bad)
                        errs++;
                end
            end
            awaiting <= pending_bytes.size();
            mismatches <= errs;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the decompressor testbench: clock, reset, stimulus, output stalls and the verdict.
module tb;
    import lzss_fbd_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PC_W-1:0]      cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'h00;
    logic                 stream_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 last_of_run;
    logic                 output_complete;
    int                   awaiting;
    int                   mismatches;

    int items_sent = 0;
    int burst_left = 0;
    int unit_now = 1;
    int stall_mode = 0;
    int stall_timer = 0;
    int stall_hold = 0;

    int unsigned plan [7][3] = '{
        '{1, 2, 24'hFFFFFF},
        '{4, 3, 24'hFFFFFF},
        '{2, 0, 5000},
        '{3, 1, 24'hFFFFFF},
        '{4, 0, 300},
        '{1, 3, 24'hFFFFFF},
        '{5, 1, 24'hFFFFFF}
    };

    always #10 clk = ~clk;

    lzss_flag_byte_decompressor DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .stream_start    (stream_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .output_complete (output_complete)
    );

    lzss_fbd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .stream_start    (stream_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .output_complete (output_complete),
        .awaiting        (awaiting),
        .mismatches      (mismatches)
    );

    // The receiver switches between no stalls, light and heavy random stalls, and long holds.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 300);
        end
        else
        begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_hold == 0)
                begin
                    out_stall <= ~out_stall;
                    stall_hold <= out_stall ? $urandom_range(1, 4) : $urandom_range(1, 20);
                end
                else
                begin
                    stall_hold <= stall_hold - 1;
                end
            end
        endcase
    end

    task automatic send_byte(input logic [7:0] value, input logic restart);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        data_byte <= value;
        stream_start <= restart;
        do @(posedge clk); while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_match(input logic [11:0] dist_field, input logic [3:0] len_field);
        send_byte({dist_field[3:0], len_field}, 1'b0);
        send_byte(dist_field[11:4], 1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
    endtask

    // A match with no output leaves no result to wait for, so a margin follows the drain.
    task automatic settle();
        drain();
        repeat (100) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input int unsigned unit, input int unsigned bias,
                              input int unsigned limit);
        settle();
        set_reg(CFG_UNIT_BYTES, PC_W'(unit));
        set_reg(CFG_LENGTH_BIAS, PC_W'(bias));
        set_reg(CFG_OUTPUT_LIMIT, PC_W'(limit));
        cfg_valid <= 1'b0;
        unit_now = (unit == 0) ? 1 : (unit > UNIT_MAX) ? UNIT_MAX : unit;
    endtask

    task automatic random_stream();
        logic [7:0]  flag_byte;
        logic [11:0] dist_field;
        int          groups;
        int          g;
        int          k;
        int          j;
        groups = $urandom_range(1, 2);
        for (g = 0; g < groups; g++)
        begin
            case ($urandom_range(0, 9))
                0: flag_byte = 8'h00;
                1: flag_byte = 8'hFF;
                default: flag_byte = 8'($urandom_range(0, 255));
            endcase
            send_byte(flag_byte, g == 0);
            for (k = 0; k < FLAG_BITS; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    drain();
                if ($urandom_range(0, 19) == 0)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                else if (flag_byte[k])
                begin
                    for (j = 0; j < unit_now; j++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: dist_field = 12'h000;
                        1, 2, 3, 4, 5: dist_field = 12'($urandom_range(1, 8));
                        6, 7: dist_field = 12'($urandom_range(1, 64));
                        8: dist_field = 12'($urandom_range(1, 1023));
                        default: dist_field = 12'($urandom_range(0, 4095));
                    endcase
                    send_match(dist_field, 4'($urandom_range(0, 15)));
                end
            end
        end
    endtask

    initial
    begin
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The first byte after reset is a flag byte even without a restart.
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_match(12'h000, 4'hF);
        send_byte(8'hFF, 1'b0);
        send_match(12'h001, 4'h0);
        send_byte(8'hA5, 1'b0);
        send_match(12'hFFF, 4'h3);

        // With four-byte units and the largest bias, the match is longer than 64 bytes.
        set_config(4, 3, 24'hFFFFFF);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_match(12'h001, 4'hF);

        // A unit of zero acts as one, a zero-length match emits nothing, and the limit cuts a copy.
        set_config(0, 0, 10);
        send_byte(8'h02, 1'b1);
        send_match(12'h001, 4'h0);
        send_byte(8'h3C, 1'b0);
        send_match(12'h001, 4'hF);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);

        // The limit drops below the bytes already produced, then a restart produces one byte.
        set_config(1, 2, 1);
        send_byte(8'h21, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'h88, 1'b0);

        set_config(4, 2, 0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h66, 1'b0);

        for (p = 0; p < 7; p++)
        begin
            set_config(plan[p][0], plan[p][1], plan[p][2]);
            random_stream();
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== lzss_flag_byte_decompressor.f =====
+incdir+rtl/core
rtl/core/lzss_fbd_pkg.sv
rtl/core/lzss_fbd_window.sv
rtl/core/lzss_fbd_outreg.sv
rtl/core/lzss_fbd_ctrl.sv
rtl/core/lzss_flag_byte_decompressor.sv
tb/lzss_fbd_checker.sv
tb/tb.sv
